FILE: rtl/core/mfa_pkg.sv
// package for the modular field alu: operation codes, widths, shared types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mfa_pkg;
    localparam int MOD_W = 63;
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_NEG = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_INV = 3'd5;
    localparam logic [2:0] OP_DIV = 3'd6;
    localparam logic [MOD_W-1:0] MOD_RESET = 63'd2305843009213693951;

    // datapath commands
    localparam logic [3:0] DC_NOP      = 4'd0;
    localparam logic [3:0] DC_LOAD     = 4'd1;  // latch raw operands, start reduction
    localparam logic [3:0] DC_RED_A    = 4'd2;  // one step of a mod m
    localparam logic [3:0] DC_RED_B    = 4'd3;  // one step of b mod m
    localparam logic [3:0] DC_SIMPLE   = 4'd4;  // add/sub/neg or pow setup into result
    localparam logic [3:0] DC_MUL_INIT = 4'd5;  // set up multiplier operands
    localparam logic [3:0] DC_MUL_STEP = 4'd6;
    localparam logic [3:0] DC_POW_MUL  = 4'd7;  // mul target: r = r*base
    localparam logic [3:0] DC_POW_SQR  = 4'd8;  // base = base*base, exp shifted right
    localparam logic [3:0] DC_INV_INIT = 4'd9;
    localparam logic [3:0] DC_DIV_INIT = 4'd10; // one quotient: r0/r1 start
    localparam logic [3:0] DC_DIV_STEP = 4'd11;
    localparam logic [3:0] DC_EUC_MUL  = 4'd12; // mul q*s1 (q < m)
    localparam logic [3:0] DC_EUC_UPD  = 4'd13;
    localparam logic [3:0] DC_INV_DONE = 4'd14;
    localparam logic [3:0] DC_FINAL    = 4'd15; // copy multiplier result into result

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] mul_sel;   // 0 a*b, 1 r*base, 2 base*base, 3 a*inv
    } dp_cmd_t;

    typedef struct packed {
        logic red_done;
        logic div_done;
        logic mul_done;
        logic exp_bit;
        logic r1_zero;
        logic inv_ok;
        logic mod_small;
    } dp_status_t;
endpackage
`default_nettype wire

FILE: rtl/core/mfa_if.sv
// valid/ready channel interface carrying the alu payloads
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface mfa_req_if #(parameter int DATA_WIDTH = 64);
    logic                  valid;
    logic                  ready;
    logic [2:0]            kind;
    logic [DATA_WIDTH-1:0] operand_a;
    logic [DATA_WIDTH-1:0] operand_b;
    modport source (output valid, kind, operand_a, operand_b, input ready);
    modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface mfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [62:0] value;
    logic        not_invertible;
    modport source (output valid, value, not_invertible, input ready);
    modport sink (input valid, value, not_invertible, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mfa_datapath.sv
// datapath: operand reduction, bit-serial modular multiplier, restoring divider
// and extended euclid registers; depends on mfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module mfa_datapath
    import mfa_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [MOD_W-1:0]      modulus,
    input  wire logic [DATA_WIDTH-1:0] in_a,
    input  wire logic [DATA_WIDTH-1:0] in_b,
    input  wire logic [2:0]            in_kind,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    output logic [MOD_W-1:0]           result
);
    localparam int CW = 7;

    logic [MOD_W-1:0] m_reg;
    logic [DATA_WIDTH-1:0] ra_reg, rb_reg, exp_reg;
    logic [MOD_W:0] rem_reg;          // running remainder for reductions and division
    logic [MOD_W-1:0] a_reg, b_reg, base_reg, res_reg;
    logic [MOD_W-1:0] mx_reg, mr_reg;
    logic [63:0] my_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0] kind_reg;
    // euclid
    logic [MOD_W-1:0] r0_reg, r1_reg, s0_reg, s1_reg, qrem_reg;
    logic [MOD_W-1:0] dq_reg;
    logic [MOD_W-1:0] dn_reg;

    function automatic logic [MOD_W-1:0] addm(input logic [MOD_W-1:0] x,
        input logic [MOD_W-1:0] y, input logic [MOD_W-1:0] m);
        logic [MOD_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= {1'b0, m}) ? MOD_W'(s - {1'b0, m}) : s[MOD_W-1:0];
    endfunction

    function automatic logic [MOD_W-1:0] subm(input logic [MOD_W-1:0] x,
        input logic [MOD_W-1:0] y, input logic [MOD_W-1:0] m);
        return (x >= y) ? x - y : m - (y - x);
    endfunction

    // restoring step shared by reduction and quotient: shift in one bit
    logic [MOD_W:0] red_sh;
    logic red_bit;
    always_comb
    begin
        red_bit = 1'b0;
        if (cmd.op == DC_RED_A)
            red_bit = ra_reg[DATA_WIDTH-1];
        else if (cmd.op == DC_RED_B)
            red_bit = rb_reg[DATA_WIDTH-1];
        else
            red_bit = dn_reg[MOD_W-1];
        red_sh = {rem_reg[MOD_W-1:0], red_bit};
    end
    logic [MOD_W:0] div_sub;
    logic div_ge;
    logic [MOD_W-1:0] divisor;
    always_comb
    begin
        divisor = (cmd.op == DC_DIV_STEP) ? r1_reg : m_reg;
        div_ge  = red_sh >= {1'b0, divisor};
        div_sub = div_ge ? red_sh - {1'b0, divisor} : red_sh;
    end

    logic [MOD_W-1:0] mul_dbl, mul_acc;
    always_comb
    begin
        mul_dbl = addm(mr_reg, mr_reg, m_reg);
        mul_acc = my_reg[63] ? addm(mul_dbl, mx_reg, m_reg) : mul_dbl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
        begin
            case (cmd.op)
                DC_LOAD, DC_MUL_INIT, DC_DIV_INIT, DC_RED_B, DC_EUC_MUL:
                    if (cmd.op == DC_RED_B && cnt_reg != CW'(DATA_WIDTH))
                        cnt_reg <= cnt_reg + 1'b1;
                    else if (cmd.op == DC_RED_B)
                        cnt_reg <= cnt_reg;
                    else
                        cnt_reg <= '0;
                DC_RED_A:
                    cnt_reg <= (cnt_reg == CW'(DATA_WIDTH)) ? '0 : cnt_reg + 1'b1;
                DC_MUL_STEP, DC_DIV_STEP:
                    cnt_reg <= cnt_reg + 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DC_LOAD:
            begin
                m_reg    <= modulus;
                ra_reg   <= in_a;
                rb_reg   <= in_b;
                exp_reg  <= in_b;
                kind_reg <= in_kind;
                rem_reg  <= '0;
            end
            DC_RED_A:
            begin
                if (cnt_reg != CW'(DATA_WIDTH))
                begin
                    ra_reg  <= ra_reg << 1;
                    rem_reg <= div_sub;
                end
                else
                begin
                    a_reg   <= rem_reg[MOD_W-1:0];
                    rem_reg <= '0;
                end
            end
            DC_RED_B:
            begin
                if (cnt_reg != CW'(DATA_WIDTH))
                begin
                    rb_reg  <= rb_reg << 1;
                    rem_reg <= div_sub;
                    b_reg   <= div_sub[MOD_W-1:0];
                end
            end
            DC_SIMPLE:
            begin
                if (m_reg < MOD_W'(2))
                    res_reg <= '0;
                else
                begin
                    case (kind_reg)
                        OP_ADD: res_reg <= addm(a_reg, b_reg, m_reg);
                        OP_SUB: res_reg <= subm(a_reg, b_reg, m_reg);
                        OP_NEG: res_reg <= (a_reg == '0) ? '0 : m_reg - a_reg;
                        OP_POW: begin res_reg <= MOD_W'(1); base_reg <= a_reg; end
                        default: res_reg <= '0;
                    endcase
                end
            end
            DC_MUL_INIT:
            begin
                mr_reg <= '0;
                case (cmd.mul_sel)
                    2'd0: begin mx_reg <= a_reg; my_reg <= {1'b0, b_reg}; end
                    2'd1: begin mx_reg <= res_reg; my_reg <= {1'b0, base_reg}; end
                    2'd2: begin mx_reg <= base_reg; my_reg <= {1'b0, base_reg}; end
                    default: begin mx_reg <= a_reg; my_reg <= {1'b0, s0_reg}; end
                endcase
            end
            DC_MUL_STEP:
            begin
                mr_reg <= mul_acc;
                my_reg <= my_reg << 1;
            end
            DC_POW_MUL: res_reg <= mr_reg;
            DC_POW_SQR:
            begin
                base_reg <= mr_reg;
                exp_reg  <= exp_reg >> 1;
            end
            DC_INV_INIT:
            begin
                r0_reg <= m_reg;
                r1_reg <= (kind_reg == OP_DIV) ? b_reg : a_reg;
                s0_reg <= '0;
                s1_reg <= MOD_W'(1);
            end
            DC_DIV_INIT:
            begin
                dn_reg  <= r0_reg;
                rem_reg <= '0;
                dq_reg  <= '0;
            end
            DC_DIV_STEP:
            begin
                dn_reg  <= dn_reg << 1;
                rem_reg <= div_sub;
                dq_reg  <= {dq_reg[MOD_W-2:0], div_ge};
            end
            DC_EUC_MUL:
            begin
                // q < m always since r0 <= m and r1 >= 1 except q==m when r1==1,r0==m
                qrem_reg <= rem_reg[MOD_W-1:0];
                mr_reg   <= '0;
                mx_reg   <= s1_reg;
                my_reg   <= {1'b0, (dq_reg >= m_reg) ? dq_reg - m_reg : dq_reg};
            end
            DC_EUC_UPD:
            begin
                r0_reg <= r1_reg;
                r1_reg <= qrem_reg;
                s0_reg <= s1_reg;
                s1_reg <= subm(s0_reg, mr_reg, m_reg);
            end
            DC_INV_DONE:
                res_reg <= (r0_reg == MOD_W'(1)) ? s0_reg : '0;
            DC_FINAL: res_reg <= mr_reg;
            default: ;
        endcase
    end

    always_comb
    begin
        status.red_done  = (cnt_reg == CW'(DATA_WIDTH));
        status.div_done  = (cnt_reg == CW'(MOD_W));
        status.mul_done  = (cnt_reg == CW'(64));
        status.exp_bit   = exp_reg[0];
        status.r1_zero   = (r1_reg == '0);
        status.inv_ok    = (r0_reg == MOD_W'(1));
        status.mod_small = (modulus < MOD_W'(2));
    end
    assign result = res_reg;
endmodule
`default_nettype wire

FILE: rtl/core/mfa_ctrl.sv
// controller state machine sequencing reduction, multiply, pow and euclid
// depends on mfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module mfa_ctrl
    import mfa_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [2:0] kind,
    input  wire dp_status_t status,
    input  wire logic       out_free,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done,
    output logic            flag
);
    localparam logic [4:0] S_IDLE = 5'd0, S_RA = 5'd1, S_RB = 5'd2, S_DISP = 5'd3,
        S_SIMPLE = 5'd4, S_MINIT = 5'd5, S_MSTEP = 5'd6, S_MEND = 5'd7,
        S_PCHK = 5'd8, S_INVI = 5'd9, S_ECHK = 5'd10, S_DINIT = 5'd11,
        S_DSTEP = 5'd12, S_EMUL = 5'd13, S_ESTEP = 5'd14, S_EUPD = 5'd15,
        S_IDONE = 5'd16, S_OUT = 5'd17, S_ZERO = 5'd18, S_DIVM = 5'd19;

    logic [4:0] state_reg, state_next;
    logic [2:0] kind_reg;
    logic [1:0] msel_reg, msel_next;   // which multiply is running
    logic [6:0] pcnt_reg, pcnt_next;   // pow bit counter
    logic flag_reg, flag_next;
    logic small_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= OP_ADD;
            msel_reg  <= 2'd0;
            pcnt_reg  <= '0;
            flag_reg  <= 1'b0;
            small_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            msel_reg  <= msel_next;
            pcnt_reg  <= pcnt_next;
            flag_reg  <= flag_next;
            if (start)
            begin
                kind_reg  <= kind;
                small_reg <= status.mod_small;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        msel_next  = msel_reg;
        pcnt_next  = pcnt_reg;
        flag_next  = flag_reg;
        cmd.op     = DC_NOP;
        cmd.mul_sel = msel_reg;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.op = DC_LOAD;
                    flag_next = 1'b0;
                    state_next = S_RA;
                end
            S_RA:
            begin
                cmd.op = DC_RED_A;
                if (status.red_done) state_next = S_RB;
            end
            S_RB:
            begin
                cmd.op = DC_RED_B;
                if (status.red_done) state_next = S_DISP;
            end
            S_DISP:
            begin
                if (small_reg || kind_reg > OP_DIV)
                    state_next = S_ZERO;
                else
                case (kind_reg)
                    OP_MUL: begin msel_next = 2'd0; state_next = S_MINIT; end
                    OP_INV, OP_DIV: state_next = S_INVI;
                    default: state_next = S_SIMPLE;
                endcase
            end
            S_ZERO:
            begin
                cmd.op = DC_SIMPLE;  // small modulus or unused kind clears the result
                state_next = S_OUT;
            end
            S_SIMPLE:
            begin
                cmd.op = DC_SIMPLE;
                pcnt_next = '0;
                state_next = (kind_reg == OP_POW) ? S_PCHK : S_OUT;
            end
            S_PCHK:
            begin
                if (pcnt_reg == 7'(DATA_WIDTH))
                    state_next = S_OUT;
                else
                begin
                    msel_next = status.exp_bit ? 2'd1 : 2'd2;
                    state_next = S_MINIT;
                end
            end
            S_MINIT:
            begin
                cmd.op = DC_MUL_INIT;
                state_next = S_MSTEP;
            end
            S_MSTEP:
            begin
                cmd.op = DC_MUL_STEP;
                if (status.mul_done) state_next = S_MEND;
                else cmd.op = DC_MUL_STEP;
                if (status.mul_done) cmd.op = DC_NOP;
            end
            S_MEND:
            begin
                case (msel_reg)
                    2'd1:
                    begin
                        cmd.op = DC_POW_MUL;
                        msel_next = 2'd2;
                        state_next = S_MINIT;
                    end
                    2'd2:
                    begin
                        cmd.op = DC_POW_SQR;
                        pcnt_next = pcnt_reg + 1'b1;
                        state_next = S_PCHK;
                    end
                    default:
                    begin
                        cmd.op = DC_FINAL;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_INVI:
            begin
                cmd.op = DC_INV_INIT;
                state_next = S_ECHK;
            end
            S_ECHK:
                state_next = status.r1_zero ? S_IDONE : S_DINIT;
            S_DINIT:
            begin
                cmd.op = DC_DIV_INIT;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                if (status.div_done) state_next = S_EMUL;
                else cmd.op = DC_DIV_STEP;
            end
            S_EMUL:
            begin
                cmd.op = DC_EUC_MUL;
                state_next = S_ESTEP;
            end
            S_ESTEP:
            begin
                if (status.mul_done) state_next = S_EUPD;
                else cmd.op = DC_MUL_STEP;
            end
            S_EUPD:
            begin
                cmd.op = DC_EUC_UPD;
                state_next = S_ECHK;
            end
            S_IDONE:
            begin
                cmd.op = DC_INV_DONE;
                if (!status.inv_ok)
                begin
                    flag_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (kind_reg == OP_DIV)
                    state_next = S_DIVM;
                else
                    state_next = S_OUT;
            end
            S_DIVM:
            begin
                msel_next = 2'd3;
                state_next = S_MINIT;
            end
            S_OUT:
                if (out_free)
                begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end
    assign busy = (state_reg != S_IDLE);
    assign flag = flag_reg;
endmodule
`default_nettype wire

FILE: rtl/core/modular_field_alu_core.sv
// Modular field alu: add, sub, mul, neg, pow, inverse and divide modulo a 63-bit
// modulus set over APB (address 0). One transaction at a time: both operands are
// reduced bit-serially, a multiply runs on the shared double-and-add unit, pow
// takes up to 128 multiplies, and inverse runs extended euclid with a restoring
// divider plus one multiply per round. Results sit in an output register so the
// next item may be accepted while a result waits; depends on mfa_pkg, mfa_if,
// mfa_ctrl, mfa_datapath
`timescale 1ns / 1ps
`default_nettype none
module modular_field_alu_core
    import mfa_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    mfa_req_if.sink          req,
    mfa_rsp_if.source        rsp
);
    localparam logic [1:0] REG_MODULUS = 2'd0;
    logic [MOD_W-1:0] mod_reg;
    dp_cmd_t cmd;
    dp_status_t status;
    logic [MOD_W-1:0] result;
    logic busy, done, flag, start;
    logic ov_reg;
    logic [MOD_W-1:0] oval_reg;
    logic oflag_reg;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= MOD_RESET;
        else if (psel && penable && pwrite && paddr == REG_MODULUS)
            mod_reg <= pwdata[MOD_W-1:0];
    end
    assign prdata = (paddr == REG_MODULUS) ? {1'b0, mod_reg} : 64'd0;

    assign req.ready = !busy;
    assign start = req.valid && req.ready;

    mfa_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .kind(req.kind), .status(status),
        .out_free(!ov_reg || rsp.ready), .cmd(cmd), .busy(busy), .done(done), .flag(flag)
    );
    mfa_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .modulus(mod_reg), .in_a(req.operand_a),
        .in_b(req.operand_b), .in_kind(req.kind), .cmd(cmd), .status(status),
        .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (done)
            ov_reg <= 1'b1;
        else if (rsp.ready)
            ov_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            oval_reg  <= flag ? '0 : result;
            oflag_reg <= flag;
        end
    end
    assign rsp.valid = ov_reg;
    assign rsp.value = oval_reg;
    assign rsp.not_invertible = oflag_reg;

    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy)
        else $error("accept did not start the controller");
    assert property (@(posedge clk) disable iff (!rst_n) done |=> rsp.valid)
        else $error("finished result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.not_invertible |-> rsp.value == '0)
        else $error("flagged result is not zero");
endmodule
`default_nettype wire

FILE: test/modular_field_alu_core_test.sv
// self-checking testbench for modular_field_alu_core: a built-in field arithmetic
// predictor checks every result; depends on mfa_pkg, mfa_if and the core
`timescale 1ns / 1ps
module modular_field_alu_core_test;
    import mfa_pkg::*;

    localparam logic [2:0]  OP_UNUSED    = 3'd7;
    localparam logic [1:0]  ADDR_MODULUS = 2'd0;
    localparam int          STALL_LIMIT  = 200000;
    localparam logic [62:0] MOD_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [62:0] value;
        logic        not_invertible;
    } field_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    mfa_req_if #(.DATA_WIDTH(64)) req ();
    mfa_rsp_if rsp ();

    modular_field_alu_core #(.DATA_WIDTH(64)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req(req),
        .rsp(rsp)
    );

    field_result_t pending_results[$];
    logic [62:0]   field_modulus;
    int            error_count;
    int            idle_cycles;
    int            send_idle_pct;
    int            recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- field arithmetic predictor ----------------
    function automatic logic [62:0] field_mul(logic [62:0] x, logic [62:0] y,
                                              logic [62:0] m);
        logic [127:0] p;
        p = {65'd0, x} * {65'd0, y};
        return 63'(p % {65'd0, m});
    endfunction

    function automatic logic [62:0] field_sub(logic [62:0] x, logic [62:0] y,
                                              logic [62:0] m);
        return (x >= y) ? x - y : m - (y - x);
    endfunction

    // extended euclid; returns 0 when x has no inverse
    function automatic logic field_inverse(logic [62:0] x, logic [62:0] m,
                                           output logic [62:0] inv);
        logic [63:0] r0;
        logic [63:0] r1;
        logic [63:0] q;
        logic [63:0] tr;
        logic [62:0] s0;
        logic [62:0] s1;
        logic [62:0] ts;
        r0 = {1'b0, m};
        r1 = {1'b0, x};
        s0 = '0;
        s1 = 63'd1;
        inv = '0;
        if (x == 0)
            return 1'b0;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            tr = r0 - q * r1;
            ts = field_sub(s0, field_mul(63'(q % {1'b0, m}), s1, m), m);
            r0 = r1;
            r1 = tr;
            s0 = s1;
            s1 = ts;
        end
        if (r0 != 1)
            return 1'b0;
        inv = s0;
        return 1'b1;
    endfunction

    function automatic field_result_t predict_field_op(logic [2:0] kind,
                                                       logic [63:0] ra,
                                                       logic [63:0] rb,
                                                       logic [62:0] m);
        field_result_t res;
        logic [62:0]   a;
        logic [62:0]   b;
        logic [62:0]   base;
        logic [62:0]   t;
        logic [63:0]   sum;
        res.value = '0;
        res.not_invertible = 1'b0;
        if (m < 2)
            return res;
        a = 63'(ra % {1'b0, m});
        b = 63'(rb % {1'b0, m});
        case (kind)
            OP_ADD:
            begin
                sum = {1'b0, a} + {1'b0, b};
                res.value = (sum >= {1'b0, m}) ? 63'(sum - {1'b0, m}) : 63'(sum);
            end
            OP_SUB: res.value = field_sub(a, b, m);
            OP_MUL: res.value = field_mul(a, b, m);
            OP_NEG: res.value = (a == 0) ? 63'd0 : m - a;
            OP_POW:
            begin
                res.value = 63'd1;
                base = a;
                for (int i = 0; i < 64; i++)
                begin
                    if (rb[i])
                        res.value = field_mul(res.value, base, m);
                    base = field_mul(base, base, m);
                end
            end
            OP_INV:
            begin
                if (!field_inverse(a, m, res.value))
                begin
                    res.value = '0;
                    res.not_invertible = 1'b1;
                end
            end
            OP_DIV:
            begin
                if (field_inverse(b, m, t))
                    res.value = field_mul(a, t, m);
                else
                    res.not_invertible = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_operation(logic [2:0] kind, logic [63:0] a, logic [63:0] b);
        int gap;
        gap = 0;
        if (send_idle_pct > 0)
            while ($urandom_range(99) < send_idle_pct && gap < 40)
                gap++;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.kind      <= kind;
        req.operand_a <= a;
        req.operand_b <= b;
        do
            @(posedge clk);
        while (!req.ready);
        pending_results.push_back(predict_field_op(kind, a, b, field_modulus));
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_modulus(logic [62:0] m);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODULUS;
        pwdata  <= {1'b0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        field_modulus = m;
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[62:0] !== m)
        begin
            $display("%0t modulus readback: expected %0d actual %0d", $time, m, prdata[62:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------- result checker ----------------
    initial
    begin
        field_result_t exp_res;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %0d/%0b",
                             $time, rsp.value, rsp.not_invertible);
                    error_count++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (rsp.value !== exp_res.value)
                    begin
                        $display("%0t value mismatch: expected %0d actual %0d",
                                 $time, exp_res.value, rsp.value);
                        error_count++;
                    end
                    if (rsp.not_invertible !== exp_res.not_invertible)
                    begin
                        $display("%0t not_invertible mismatch: expected %0b actual %0b",
                                 $time, exp_res.not_invertible, rsp.not_invertible);
                        error_count++;
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(5))
            0: return 64'($urandom_range(9));
            1: return {1'b0, field_modulus} - 64'($urandom_range(1));
            2: return {1'b0, field_modulus} * 64'($urandom_range(3));
            default: return rand64();
        endcase
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(99);
        // pow, inv and div get smaller shares than add, sub and mul to bound run time
        if (r < 15) return OP_ADD;
        if (r < 30) return OP_SUB;
        if (r < 48) return OP_MUL;
        if (r < 60) return OP_NEG;
        if (r < 72) return OP_POW;
        if (r < 84) return OP_INV;
        if (r < 96) return OP_DIV;
        return OP_UNUSED;
    endfunction

    task automatic test_operand_extremes();
        send_operation(OP_ADD, '1, '1);
        send_operation(OP_SUB, '0, '1);
        send_operation(OP_MUL, '1, 64'h8000_0000_0000_0000);
        send_operation(OP_NEG, '0, '0);
        send_operation(OP_NEG, 64'd5, '1);
        send_operation(OP_POW, 64'd3, '1);
        send_operation(OP_INV, 64'd2, '0);
        send_operation(OP_DIV, '1, 64'd7);
        send_operation(OP_UNUSED, '1, '1);
    endtask

    task automatic test_special_cases();
        send_operation(OP_POW, '0, '0);
        send_operation(OP_POW, 64'd12345, '0);
        send_operation(OP_INV, '0, 64'd1);
        send_operation(OP_INV, {1'b0, field_modulus}, '0);
        send_operation(OP_DIV, 64'd9, '0);
        write_modulus(63'd1000000);
        send_operation(OP_INV, 64'd10, '0);
        send_operation(OP_DIV, 64'd3, 64'd4);
        send_operation(OP_INV, 64'd7, '0);
        send_operation(OP_DIV, 64'd3, 64'd999999);
    endtask

    task automatic test_small_modulus();
        logic [62:0] m;
        for (int i = 0; i < 3; i++)
        begin
            m = 63'(i);
            write_modulus(m);
            send_operation(OP_ADD, rand64(), rand64());
            send_operation(OP_POW, rand64(), '0);
            send_operation(OP_INV, 64'd1, '0);
        end
    endtask

    task automatic test_random_traffic(int count);
        logic [62:0] moduli[4];
        moduli[0] = MOD_MAX;
        moduli[1] = MOD_RESET;
        moduli[2] = 63'd1000003;
        moduli[3] = 63'(rand64()) | 63'h4000_0000_0000_0000;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_modulus(moduli[phase]);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int i = 0; i < count / 4; i++)
                send_operation(pick_kind(), pick_operand(), pick_operand());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        field_modulus  = MOD_RESET;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req.valid      = 1'b0;
        req.kind       = '0;
        req.operand_a  = '0;
        req.operand_b  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operand_extremes();
        test_special_cases();
        test_small_modulus();
        test_random_traffic(76);

        drain_results();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: modular_field_alu_core.f
rtl/core/mfa_pkg.sv
rtl/core/mfa_if.sv
rtl/core/mfa_datapath.sv
rtl/core/mfa_ctrl.sv
rtl/core/modular_field_alu_core.sv
test/modular_field_alu_core_test.sv
